// File: rtl/morse_keying_sequencer_top_defines.svh
// Assertion helpers included by the sequencer RTL
`ifndef MORSE_KEYING_SEQUENCER_TOP_DEFINES_SVH
`define MORSE_KEYING_SEQUENCER_TOP_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define MKS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mks assertion failed");

// expression must never be true out of reset
`define MKS_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mks forbidden condition seen");

`endif

// File: rtl/mks_pkg.sv
package mks_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_TONE_WORD = 2'd0;
    localparam logic [1:0] REG_UNIT_MS   = 2'd1;
    localparam logic [1:0] REG_EGAP_MS   = 2'd2;
    localparam logic [1:0] REG_CGAP_MS   = 2'd3;

    localparam logic [15:0] TONE_WORD_RST = 16'd2867;
    localparam logic [9:0]  UNIT_MS_RST   = 10'd100;
    localparam logic [9:0]  EGAP_MS_RST   = 10'd50;
    localparam logic [12:0] CGAP_MS_RST   = 13'd300;

    typedef struct packed {
        logic [15:0] tone_word;
        logic [9:0]  unit_ms;
        logic [9:0]  element_gap_ms;
        logic [12:0] char_gap_ms;
    } cfg_t;

    // n: element count (0 = uncoded), dash: bit i set when element i is a dash
    typedef struct packed {
        logic [2:0] n;
        logic [4:0] dash;
    } pattern_t;

    function automatic pattern_t morse_lookup(input logic [7:0] c);
        pattern_t p;
        p.n    = 3'd0;
        p.dash = 5'b00000;
        unique case (c)
            8'h30: p = '{3'd5, 5'b11111};
            8'h31: p = '{3'd5, 5'b11110};
            8'h32: p = '{3'd5, 5'b11100};
            8'h33: p = '{3'd5, 5'b11000};
            8'h34: p = '{3'd5, 5'b10000};
            8'h35: p = '{3'd5, 5'b00000};
            8'h36: p = '{3'd5, 5'b00001};
            8'h37: p = '{3'd5, 5'b00011};
            8'h38: p = '{3'd5, 5'b00111};
            8'h39: p = '{3'd5, 5'b01111};
            8'h41: p = '{3'd2, 5'b00010};
            8'h42: p = '{3'd4, 5'b00001};
            8'h43: p = '{3'd4, 5'b00101};
            8'h44: p = '{3'd3, 5'b00001};
            8'h45: p = '{3'd1, 5'b00000};
            8'h46: p = '{3'd4, 5'b00100};
            8'h47: p = '{3'd3, 5'b00011};
            8'h48: p = '{3'd4, 5'b00000};
            8'h49: p = '{3'd2, 5'b00000};
            8'h4A: p = '{3'd4, 5'b01110};
            8'h4B: p = '{3'd3, 5'b00101};
            8'h4C: p = '{3'd4, 5'b00010};
            8'h4D: p = '{3'd2, 5'b00011};
            8'h4E: p = '{3'd2, 5'b00001};
            8'h4F: p = '{3'd3, 5'b00111};
            8'h50: p = '{3'd4, 5'b00110};
            8'h51: p = '{3'd4, 5'b01011};
            8'h52: p = '{3'd3, 5'b00010};
            8'h53: p = '{3'd3, 5'b00000};
            8'h54: p = '{3'd1, 5'b00001};
            8'h55: p = '{3'd3, 5'b00100};
            8'h56: p = '{3'd4, 5'b01000};
            8'h57: p = '{3'd3, 5'b00110};
            8'h58: p = '{3'd4, 5'b01001};
            8'h59: p = '{3'd4, 5'b01101};
            8'h5A: p = '{3'd4, 5'b00011};
            default: p = '{3'd0, 5'b00000};
        endcase
        return p;
    endfunction

endpackage

// File: rtl/mks_if.sv
interface mks_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

interface mks_seg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tone_out;
    logic [12:0] duration_ms;
    logic        last;

    modport source (output valid, output tone_out, output duration_ms, output last,
                     input ready);
    modport sink   (input valid, input tone_out, input duration_ms, input last,
                     output ready);
endinterface

// File: rtl/mks_regs.sv
module mks_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mks_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mks_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mks_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output mks_pkg::cfg_t                   cfg
);

    mks_pkg::cfg_t cfg_reg;
    logic [1:0]    idx;
    logic          wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_word      <= mks_pkg::TONE_WORD_RST;
            cfg_reg.unit_ms        <= mks_pkg::UNIT_MS_RST;
            cfg_reg.element_gap_ms <= mks_pkg::EGAP_MS_RST;
            cfg_reg.char_gap_ms    <= mks_pkg::CGAP_MS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mks_pkg::REG_TONE_WORD: cfg_reg.tone_word      <= pwdata[15:0];
                mks_pkg::REG_UNIT_MS:   cfg_reg.unit_ms        <= pwdata[9:0];
                mks_pkg::REG_EGAP_MS:   cfg_reg.element_gap_ms <= pwdata[9:0];
                mks_pkg::REG_CGAP_MS:   cfg_reg.char_gap_ms    <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mks_pkg::REG_TONE_WORD: prdata = {16'd0, cfg_reg.tone_word};
            mks_pkg::REG_UNIT_MS:   prdata = {22'd0, cfg_reg.unit_ms};
            mks_pkg::REG_EGAP_MS:   prdata = {22'd0, cfg_reg.element_gap_ms};
            mks_pkg::REG_CGAP_MS:   prdata = {19'd0, cfg_reg.char_gap_ms};
            default:                prdata = '0;
        endcase
    end

endmodule

// File: rtl/mks_seq.sv
`include "morse_keying_sequencer_top_defines.svh"

module mks_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  mks_pkg::cfg_t      cfg,
    mks_char_if.sink           chars,
    mks_seg_if.source          segs
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEG  = 3'b010,
        S_CALC = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  left_reg, left_next;      // elements still to send
    logic [4:0]  dash_reg, dash_next;      // bit 0 = current element
    logic        key_reg, key_next;        // next segment is key-down
    logic [15:0] tone_reg, tone_next;
    logic [12:0] dur_reg, dur_next;
    logic        last_reg, last_next;

    mks_pkg::pattern_t pat;
    logic        in_fire;
    logic        out_fire;
    logic [12:0] key_dur;

    assign pat      = mks_pkg::morse_lookup(chars.ascii_char);
    assign in_fire  = chars.valid && chars.ready;
    assign out_fire = segs.valid && segs.ready;

    assign chars.ready      = (state_reg == S_IDLE);
    assign segs.valid       = (state_reg == S_SEG);
    assign segs.tone_out    = tone_reg;
    assign segs.duration_ms = dur_reg;
    assign segs.last        = last_reg;

    // adder: unit or 3*unit = unit + 2*unit
    assign key_dur = {3'd0, cfg.unit_ms}
                   + (dash_reg[0] ? {2'd0, cfg.unit_ms, 1'b0} : 13'd0);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        dash_next  = dash_reg;
        key_next   = key_reg;
        tone_next  = tone_reg;
        dur_next   = dur_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    left_next  = pat.n;
                    dash_next  = pat.dash;
                    key_next   = 1'b1;
                    tone_next  = 16'd0;
                    dur_next   = cfg.char_gap_ms;
                    last_next  = (pat.n == 3'd0);
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (out_fire)
                    state_next = last_reg ? S_IDLE : S_CALC;
            end
            S_CALC:
            begin
                if (key_reg)
                begin
                    tone_next = cfg.tone_word;
                    dur_next  = key_dur;
                    last_next = 1'b0;
                    key_next  = 1'b0;
                end
                else
                begin
                    tone_next = 16'd0;
                    dur_next  = {3'd0, cfg.element_gap_ms};
                    last_next = (left_reg == 3'd1);
                    left_next = left_reg - 3'd1;
                    dash_next = {1'b0, dash_reg[4:1]};
                    key_next  = 1'b1;
                end
                state_next = S_SEG;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            left_reg  <= 3'd0;
            key_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            key_reg   <= key_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dash_reg <= dash_next;
        tone_reg <= tone_next;
        dur_reg  <= dur_next;
    end

    // a new char always opens with a silent gap word
    `MKS_ASSERT(a_gap_first, in_fire |=> (segs.valid && (segs.tone_out == 16'd0)))
    // every non-final word taken is followed by the compute state
    `MKS_ASSERT(a_calc_after, (out_fire && !segs.last) |=> !segs.valid)
    // last word taken returns to accepting chars
    `MKS_ASSERT(a_idle_after_last, (out_fire && segs.last) |=> chars.ready)
    `MKS_NEVER(a_left_range, left_reg > 3'd5)

endmodule

// File: rtl/morse_keying_sequencer_top.sv
// channel  | dir | payload                          | role
// chars    | in  | ascii_char[7:0]                  | one char per word
// segs     | out | tone_out, duration_ms, last      | keying segments, last ends char
// apb      | in  | 4 regs at paddr 0,4,8,12         | tone, unit, elem gap, char gap
//
// A char yields 1 + 2n words (n = 0..5 elements); each word after the first
// is computed in the sequencer's S_CALC state before it is output in S_SEG.
// chars.ready is high only while no run is in progress.
// A stalled segs.ready holds the current word; rst_n restores register defaults.
module morse_keying_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mks_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mks_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mks_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    mks_char_if.sink                        chars,
    mks_seg_if.source                       segs
);

    mks_pkg::cfg_t cfg;

    mks_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mks_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .chars (chars),
        .segs  (segs)
    );

endmodule
